// File: src/psv_pkg.sv
// shared constants, types and codes for the plucked string voice
`default_nettype none

package psv_pkg;

    localparam int MAX_DELAY = 4096;
    localparam int ADDR_W    = $clog2(MAX_DELAY);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int SMP_W     = 16;
    localparam int ENV_W     = 24;
    localparam int CFG_W     = 24;

    // shift-add multiplier sizing
    localparam int MUL_A_W   = 26;
    localparam int MUL_B_W   = 24;
    localparam int MUL_CNT_W = 5;

    localparam logic [ENV_W-1:0] ENV_ONE       = 24'd8388608;
    localparam logic [ENV_W-1:0] ENV_THRESHOLD = 24'd84;

    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DELAY);

    // opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_DELAY_LENGTH = 2'd0;
    localparam logic [1:0] CFG_LOOP_DAMPING = 2'd1;
    localparam logic [1:0] CFG_DECAY_FACTOR = 2'd2;
    localparam logic [1:0] CFG_PLUCK_GAIN   = 2'd3;

    localparam logic [12:0] RST_DELAY_LENGTH = 13'd436;
    localparam logic [15:0] RST_LOOP_DAMPING = 16'd65405;
    localparam logic [23:0] RST_DECAY_FACTOR = 24'd16776924;
    localparam logic [15:0] RST_PLUCK_GAIN   = 16'd32768;

    // multiply steps for each product
    localparam logic [MUL_CNT_W-1:0] STEPS_AVG = MUL_CNT_W'(17);
    localparam logic [MUL_CNT_W-1:0] STEPS_ENV = MUL_CNT_W'(24);
    localparam logic [MUL_CNT_W-1:0] STEPS_Y1  = MUL_CNT_W'(24);
    localparam logic [MUL_CNT_W-1:0] STEPS_Y   = MUL_CNT_W'(16);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_MUL1,
        S_MUL2,
        S_DONE
    } psv_state_t;

    typedef struct packed {
        logic                 start;
        logic [MUL_CNT_W-1:0] steps;
        logic [MUL_A_W-1:0]   a;
        logic [MUL_B_W-1:0]   b;
    } psv_mul_cmd_t;

endpackage

`default_nettype wire

// File: src/psv_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module psv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: src/psv_smul.sv
// bit-serial signed by unsigned multiplier, floor of a*b over 2^steps
`default_nettype none

module psv_smul
    import psv_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire psv_mul_cmd_t                cmd,
    output logic                             busy,
    output logic signed [MUL_A_W-1:0]        result
);

    logic                        busy_reg, busy_next;
    logic [MUL_CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [MUL_A_W-1:0]   acc_reg, acc_next;
    logic signed [MUL_A_W-1:0]   a_reg, a_next;
    logic [MUL_B_W-1:0]          b_reg, b_next;
    logic signed [MUL_A_W:0]     sum;

    // one multiplier bit per cycle, lsb first; dropping the shifted-out bit floors
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        sum       = {acc_reg[MUL_A_W-1], acc_reg}
                  + (b_reg[0] ? {a_reg[MUL_A_W-1], a_reg} : '0);
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.steps;
            acc_next  = '0;
            a_next    = $signed(cmd.a);
            b_next    = cmd.b;
        end
        else if (busy_reg)
        begin
            acc_next = sum[MUL_A_W:1];
            b_next   = {1'b0, b_reg[MUL_B_W-1:1]};
            cnt_next = cnt_reg - MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

// File: src/plucked_string_voice_core.sv
// plucked string voice: delay line, serial multipliers and item sequencer
// start and load words are handled in idle; a tick's result word follows acceptance after
// two line reads and two rounds of bit-serial multiplies, a finished tick skips straight to it
// start and load every cycle; a tick holds off the next word until its result word is registered;
// an untaken result word holds the next tick in its last step
// reset: registers and voice state return to their defaults; the delay line
// is not cleared and holds garbage until loaded
`default_nettype none

module plucked_string_voice_core
    import psv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [15:0] excitation_noise,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      sample_out,
    output logic                    finished,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    localparam logic signed [MUL_A_W-1:0] SAT_MAX = MUL_A_W'(32767);
    localparam logic signed [MUL_A_W-1:0] SAT_MIN = -MUL_A_W'(32768);

    psv_state_t state_reg, state_next;

    logic [12:0]              delay_len_reg;
    logic [15:0]              damping_reg;
    logic [23:0]              decay_reg;
    logic [15:0]              gain_reg;

    logic [ADDR_W-1:0]        load_idx_reg, load_idx_next;
    logic signed [SMP_W-1:0]  prev_noise_reg, prev_noise_next;
    logic [ADDR_W-1:0]        read_pos_reg, read_pos_next;
    logic [ENV_W-1:0]         env_reg, env_next;
    logic                     done_reg, done_next;
    logic [ADDR_W-1:0]        rp_reg, rp_next;
    logic [ADDR_W-1:0]        np_reg, np_next;
    logic signed [SMP_W-1:0]  cur_reg, cur_next;
    logic signed [SMP_W-1:0]  pend_sample_reg, pend_sample_next;
    logic                     pend_fin_reg, pend_fin_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [SMP_W-1:0]  sample_reg, sample_next;
    logic                     fin_reg, fin_next;

    logic [LEN_W-1:0]         len;
    logic [ADDR_W-1:0]        load_pos;
    logic [LEN_W-1:0]         load_inc;
    logic [ADDR_W-1:0]        tick_rp;
    logic [LEN_W-1:0]         tick_inc;
    logic signed [SMP_W:0]    noise_sum;
    logic signed [SMP_W:0]    line_sum;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [SMP_W-1:0]         ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [SMP_W-1:0]         ram_rdata;

    psv_mul_cmd_t             mul0_cmd, mul1_cmd;
    logic                     mul0_busy, mul1_busy;
    logic signed [MUL_A_W-1:0] mul0_res, mul1_res;

    psv_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MAX_DELAY)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // unit 0: output path, unit 1: loop filter then envelope
    psv_smul u_mul0 (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mul0_cmd),
        .busy   (mul0_busy),
        .result (mul0_res)
    );

    psv_smul u_mul1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mul1_cmd),
        .busy   (mul1_busy),
        .result (mul1_res)
    );

    // effective loop length clamped between two and the line size
    always_comb
    begin
        if (delay_len_reg < LEN_MIN)
        begin
            len = LEN_MIN;
        end
        else if (delay_len_reg > LEN_MAX)
        begin
            len = LEN_MAX;
        end
        else
        begin
            len = delay_len_reg;
        end
    end

    assign load_pos  = ({1'b0, load_idx_reg} >= len) ? '0 : load_idx_reg;
    assign load_inc  = {1'b0, load_pos} + LEN_W'(1);
    assign tick_rp   = ({1'b0, read_pos_reg} < len) ? read_pos_reg : '0;
    assign tick_inc  = {1'b0, tick_rp} + LEN_W'(1);
    assign noise_sum = {excitation_noise[SMP_W-1], excitation_noise}
                     + {prev_noise_reg[SMP_W-1], prev_noise_reg};
    assign line_sum  = {cur_reg[SMP_W-1], cur_reg}
                     + {ram_rdata[SMP_W-1], ram_rdata};

    assign ram_raddr = (state_reg == S_RD0) ? rp_reg : np_reg;

    always_comb
    begin
        state_next       = state_reg;
        load_idx_next    = load_idx_reg;
        prev_noise_next  = prev_noise_reg;
        read_pos_next    = read_pos_reg;
        env_next         = env_reg;
        done_next        = done_reg;
        rp_next          = rp_reg;
        np_next          = np_reg;
        cur_next         = cur_reg;
        pend_sample_next = pend_sample_reg;
        pend_fin_next    = pend_fin_reg;
        out_valid_next   = out_valid_reg;
        sample_next      = sample_reg;
        fin_next         = fin_reg;
        ram_we           = 1'b0;
        ram_waddr        = load_pos;
        ram_wdata        = noise_sum[SMP_W:1];
        mul0_cmd         = '0;
        mul1_cmd         = '0;
        in_ready         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (opcode)
                        OP_START:
                        begin
                            load_idx_next   = '0;
                            prev_noise_next = '0;
                            read_pos_next   = '0;
                            env_next        = ENV_ONE;
                            done_next       = 1'b0;
                        end
                        OP_LOAD:
                        begin
                            ram_we          = 1'b1;
                            prev_noise_next = excitation_noise;
                            load_idx_next   = (load_inc >= len) ? '0 : load_inc[ADDR_W-1:0];
                        end
                        OP_TICK:
                        begin
                            if (done_reg || env_reg < ENV_THRESHOLD)
                            begin
                                done_next        = 1'b1;
                                pend_sample_next = '0;
                                pend_fin_next    = 1'b1;
                                state_next       = S_DONE;
                            end
                            else
                            begin
                                rp_next       = tick_rp;
                                np_next       = (tick_inc >= len) ? '0 : tick_inc[ADDR_W-1:0];
                                read_pos_next = np_next;
                                state_next    = S_RD0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cur_next   = ram_rdata;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                // cur * env over 2^23, run as 2*cur over 2^24
                mul0_cmd.start = 1'b1;
                mul0_cmd.steps = STEPS_Y1;
                mul0_cmd.a     = {{(MUL_A_W-SMP_W-1){cur_reg[SMP_W-1]}}, cur_reg, 1'b0};
                mul0_cmd.b     = env_reg;
                mul1_cmd.start = 1'b1;
                mul1_cmd.steps = STEPS_AVG;
                mul1_cmd.a     = {{(MUL_A_W-SMP_W-1){line_sum[SMP_W]}}, line_sum};
                mul1_cmd.b     = {{(MUL_B_W-16){1'b0}}, damping_reg};
                state_next     = S_MUL1;
            end
            S_MUL1:
            begin
                if (!mul0_busy && !mul1_busy)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = rp_reg;
                    ram_wdata      = mul1_res[SMP_W-1:0];
                    // y1 * gain over 2^15, run as 2*y1 over 2^16
                    mul0_cmd.start = 1'b1;
                    mul0_cmd.steps = STEPS_Y;
                    mul0_cmd.a     = {{(MUL_A_W-SMP_W-2){mul0_res[SMP_W]}},
                                      mul0_res[SMP_W:0], 1'b0};
                    mul0_cmd.b     = {{(MUL_B_W-16){1'b0}}, gain_reg};
                    mul1_cmd.start = 1'b1;
                    mul1_cmd.steps = STEPS_ENV;
                    mul1_cmd.a     = {{(MUL_A_W-ENV_W){1'b0}}, env_reg};
                    mul1_cmd.b     = decay_reg;
                    state_next     = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (!mul0_busy && !mul1_busy)
                begin
                    env_next      = mul1_res[ENV_W-1:0];
                    pend_fin_next = 1'b0;
                    if (mul0_res > SAT_MAX)
                    begin
                        pend_sample_next = SAT_MAX[SMP_W-1:0];
                    end
                    else if (mul0_res < SAT_MIN)
                    begin
                        pend_sample_next = SAT_MIN[SMP_W-1:0];
                    end
                    else
                    begin
                        pend_sample_next = mul0_res[SMP_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // output word register frees as soon as the old word is taken
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = pend_sample_reg;
                    fin_next       = pend_fin_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            load_idx_reg   <= '0;
            prev_noise_reg <= '0;
            read_pos_reg   <= '0;
            env_reg        <= ENV_ONE;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_idx_reg   <= load_idx_next;
            prev_noise_reg <= prev_noise_next;
            read_pos_reg   <= read_pos_next;
            env_reg        <= env_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg          <= rp_next;
        np_reg          <= np_next;
        cur_reg         <= cur_next;
        pend_sample_reg <= pend_sample_next;
        pend_fin_reg    <= pend_fin_next;
        sample_reg      <= sample_next;
        fin_reg         <= fin_next;
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_len_reg <= RST_DELAY_LENGTH;
            damping_reg   <= RST_LOOP_DAMPING;
            decay_reg     <= RST_DECAY_FACTOR;
            gain_reg      <= RST_PLUCK_GAIN;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DELAY_LENGTH: delay_len_reg <= cfg_data[12:0];
                CFG_LOOP_DAMPING: damping_reg   <= cfg_data[15:0];
                CFG_DECAY_FACTOR: decay_reg     <= cfg_data[23:0];
                CFG_PLUCK_GAIN:   gain_reg      <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;
    assign finished   = fin_reg;

    a_finished_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> sample_out == '0)
        else $error("finished word carries a nonzero sample");

    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mul0_busy && !mul1_busy)
        else $error("multiplier still busy while sequencer is idle");

    a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
        env_reg <= ENV_ONE)
        else $error("envelope above one");

    a_taps_apart: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD0 |-> rp_reg != np_reg && {1'b0, rp_reg} < len)
        else $error("line taps collide or fall outside the loop");

endmodule

`default_nettype wire

// File: bench/psv_voice_checker.sv
// checker for the plucked string voice: predicts every tick sample and compares it
`timescale 1ns / 100ps

module psv_voice_checker
    import psv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [15:0] excitation_noise,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [15:0] sample_out,
    input  wire logic               finished,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    output int                      mismatch_count,
    output int                      samples_owed
);

    typedef struct packed {
        logic signed [15:0] sample;
        logic               done;
    } voice_sample_t;

    voice_sample_t      expected_samples[$];
    voice_sample_t      oldest;

    logic signed [15:0] line_mem [MAX_DELAY];
    int                 fill_pos;
    int                 ring_pos;
    logic signed [15:0] last_noise;
    logic [ENV_W-1:0]   env_level;
    logic               voice_silent;

    logic [12:0]        len_reg;
    logic [15:0]        damp_reg;
    logic [23:0]        decay_reg;
    logic [15:0]        gain_reg;

    function automatic int loop_span();
        if (len_reg < LEN_MIN)
            return int'(LEN_MIN);
        if (len_reg > LEN_MAX)
            return int'(LEN_MAX);
        return int'(len_reg);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // advance the voice by one accepted word and queue the sample if it is a tick
    task automatic voice_step(input logic [1:0] op, input logic signed [15:0] noise);
        int            span;
        int            rp;
        int            np;
        longint        cur;
        longint        nxt;
        longint        avg;
        longint        y;
        voice_sample_t res;
        span = loop_span();
        case (op)
            OP_START:
            begin
                fill_pos     = 0;
                ring_pos     = 0;
                last_noise   = '0;
                env_level    = ENV_ONE;
                voice_silent = 1'b0;
            end
            OP_LOAD:
            begin
                if (fill_pos >= span)
                    fill_pos = 0;
                line_mem[fill_pos] = 16'((longint'(noise) + longint'(last_noise)) >>> 1);
                last_noise = noise;
                fill_pos = (fill_pos + 1 >= span) ? 0 : fill_pos + 1;
            end
            OP_TICK:
            begin
                if (voice_silent || env_level < ENV_THRESHOLD)
                begin
                    voice_silent = 1'b1;
                    res.sample   = '0;
                    res.done     = 1'b1;
                end
                else
                begin
                    rp  = (ring_pos < span) ? ring_pos : 0;
                    np  = (rp + 1 >= span) ? 0 : rp + 1;
                    cur = longint'(line_mem[rp]);
                    nxt = longint'(line_mem[np]);
                    avg = ((cur + nxt) * longint'(damp_reg)) >>> 17;
                    line_mem[rp] = 16'(avg);
                    ring_pos = np;
                    y = (cur * longint'(env_level)) >>> 23;
                    y = (y * longint'(gain_reg)) >>> 15;
                    if (y > 32767)
                        y = 32767;
                    if (y < -32768)
                        y = -32768;
                    env_level = ENV_W'((longint'(env_level) * longint'(decay_reg)) >>> 24);
                    res.sample = 16'(y);
                    res.done   = 1'b0;
                end
                expected_samples.push_back(res);
            end
            default:
            begin
                // unused opcode, nothing happens
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_samples.delete();
            fill_pos       = 0;
            ring_pos       = 0;
            last_noise     = '0;
            env_level      = ENV_ONE;
            voice_silent   = 1'b0;
            len_reg        = RST_DELAY_LENGTH;
            damp_reg       = RST_LOOP_DAMPING;
            decay_reg      = RST_DECAY_FACTOR;
            gain_reg       = RST_PLUCK_GAIN;
            mismatch_count = 0;
            samples_owed   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("unexpected sample word %0d finished %0b",
                                              sample_out, finished));
                else
                begin
                    oldest = expected_samples.pop_front();
                    if (sample_out !== oldest.sample)
                        report_mismatch($sformatf("sample_out got %0d expected %0d",
                                                  sample_out, oldest.sample));
                    if (finished !== oldest.done)
                        report_mismatch($sformatf("finished got %0b expected %0b",
                                                  finished, oldest.done));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DELAY_LENGTH: len_reg   = cfg_data[12:0];
                    CFG_LOOP_DAMPING: damp_reg  = cfg_data[15:0];
                    CFG_DECAY_FACTOR: decay_reg = cfg_data[23:0];
                    CFG_PLUCK_GAIN:   gain_reg  = cfg_data[15:0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
                voice_step(opcode, excitation_noise);
            samples_owed = expected_samples.size();
        end
    end

endmodule

// File: bench/tb.sv
// testbench top: drives plucks, loads and ticks into the voice and gives the verdict
`timescale 1ns / 100ps

module tb;
    import psv_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         PHASE_WORDS  = 160;
    localparam int         SETTLE       = 70;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic signed [15:0] excitation_noise;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] sample_out;
    logic               finished;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    int                 mismatch_count;
    int                 samples_owed;

    int                 sender_idle;
    int                 receiver_stall;

    // stimulus-side view of the voice so that no tick reads a line entry never loaded
    bit                 loaded [MAX_DELAY];
    int                 gen_fill;
    int                 gen_ring;
    logic [ENV_W-1:0]   gen_env;
    bit                 gen_silent;
    logic [12:0]        gen_len_reg;
    logic [23:0]        gen_decay;

    plucked_string_voice_core dut (.*);

    psv_voice_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99, 0) >= receiver_stall);

    initial
    begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic int gen_span();
        if (gen_len_reg < LEN_MIN)
            return int'(LEN_MIN);
        if (gen_len_reg > LEN_MAX)
            return int'(LEN_MAX);
        return int'(gen_len_reg);
    endfunction

    function automatic bit tick_reads_loaded();
        int span;
        int rp;
        int np;
        span = gen_span();
        if (gen_silent || gen_env < ENV_THRESHOLD)
            return 1'b1;
        rp = (gen_ring < span) ? gen_ring : 0;
        np = (rp + 1 >= span) ? 0 : rp + 1;
        return loaded[rp] && loaded[np];
    endfunction

    function automatic logic signed [15:0] pick_noise();
        case ($urandom_range(9, 0))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'shFFFF;
            3:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [1:0] op, input logic signed [15:0] noise);
        int span;
        int rp;
        int np;
        // a tick that would read an unloaded entry becomes a load instead
        if (op == OP_TICK && !tick_reads_loaded())
            op = OP_LOAD;
        @(negedge clk);
        while ($urandom_range(99, 0) < sender_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid         = 1'b1;
        opcode           = op;
        excitation_noise = noise;
        do
            @(posedge clk);
        while (!in_ready);
        span = gen_span();
        case (op)
            OP_START:
            begin
                gen_fill   = 0;
                gen_ring   = 0;
                gen_env    = ENV_ONE;
                gen_silent = 1'b0;
            end
            OP_LOAD:
            begin
                if (gen_fill >= span)
                    gen_fill = 0;
                loaded[gen_fill] = 1'b1;
                gen_fill = (gen_fill + 1 >= span) ? 0 : gen_fill + 1;
            end
            OP_TICK:
            begin
                if (gen_silent || gen_env < ENV_THRESHOLD)
                    gen_silent = 1'b1;
                else
                begin
                    rp = (gen_ring < span) ? gen_ring : 0;
                    np = (rp + 1 >= span) ? 0 : rp + 1;
                    gen_ring = np;
                    gen_env = ENV_W'((longint'(gen_env) * longint'(gen_decay)) >>> 24);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic pause_for_samples();
        @(negedge clk);
        in_valid = 1'b0;
        while (samples_owed != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == CFG_DELAY_LENGTH)
            gen_len_reg = value[12:0];
        else if (idx == CFG_DECAY_FACTOR)
            gen_decay = value[23:0];
    endtask

    // registers change only once the voice has gone quiet
    task automatic set_voice_regs(input logic [12:0] len_v, input logic [15:0] damp_v,
                                  input logic [23:0] decay_v, input logic [15:0] gain_v);
        pause_for_samples();
        repeat (SETTLE) @(negedge clk);
        write_reg(CFG_DELAY_LENGTH, CFG_W'(len_v));
        write_reg(CFG_LOOP_DAMPING, CFG_W'(damp_v));
        write_reg(CFG_DECAY_FACTOR, decay_v);
        write_reg(CFG_PLUCK_GAIN, CFG_W'(gain_v));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [12:0] len_v, input logic [15:0] damp_v,
                             input logic [23:0] decay_v, input logic [15:0] gain_v);
        int issued;
        int span;
        int loads;
        int ticks;
        int pick;
        bit first;
        sender_idle    = 0;
        receiver_stall = 0;
        set_voice_regs(len_v, damp_v, decay_v, gain_v);
        sender_idle    = idle_pct;
        receiver_stall = stall_pct;
        issued = 0;
        first  = 1'b1;
        while (issued < PHASE_WORDS)
        begin
            if ($urandom_range(7, 0) == 0)
                pause_for_samples();
            // the first pluck of a phase sometimes skips the start to meet stale positions
            if (first ? ($urandom_range(1, 0) == 0) : ($urandom_range(9, 0) != 0))
            begin
                send_word(OP_START, pick_noise());
                issued++;
            end
            span  = gen_span();
            loads = (span <= 64) ? span + $urandom_range(3, 0) : $urandom_range(64, 2);
            repeat (loads)
            begin
                if (issued < PHASE_WORDS)
                begin
                    send_word(OP_LOAD, pick_noise());
                    issued++;
                end
            end
            ticks = $urandom_range(90, 4);
            repeat (ticks)
            begin
                if (issued < PHASE_WORDS)
                begin
                    pick = $urandom_range(99, 0);
                    if (pick < 3)
                        send_word(OP_UNUSED, pick_noise());
                    else
                    begin
                        if (pick < 6)
                            send_word(OP_LOAD, pick_noise());
                        else if (pick < 7)
                            send_word(OP_START, pick_noise());
                        else
                            send_word(OP_TICK, pick_noise());
                        issued++;
                    end
                end
            end
            first = 1'b0;
        end
    endtask

    initial
    begin
        logic signed [15:0] edge_noise [9];
        int                 w;
        edge_noise = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'shFFFF,
                       16'sh0001, 16'sh5555, 16'shAAAA, 16'sh0000};
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        opcode           = OP_START;
        excitation_noise = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_DELAY_LENGTH;
        cfg_data         = '0;
        sender_idle      = 0;
        receiver_stall   = 0;
        gen_fill         = 0;
        gen_ring         = 0;
        gen_env          = ENV_ONE;
        gen_silent       = 1'b0;
        gen_len_reg      = RST_DELAY_LENGTH;
        gen_decay        = RST_DECAY_FACTOR;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // full-scale and alternating noise under the reset settings
        send_word(OP_START, '0);
        for (w = 0; w < 9; w++)
            send_word(OP_LOAD, edge_noise[w]);
        repeat (6) send_word(OP_TICK, '0);
        send_word(OP_UNUSED, 16'sh7FFF);
        send_word(OP_TICK, '0);

        // shortest loop, wrapping loads, gain past unity and a voice that dies at once
        set_voice_regs(13'd0, 16'd65535, 24'd0, 16'd65535);
        send_word(OP_START, '0);
        repeat (3) send_word(OP_LOAD, 16'sh7FFF);
        repeat (3) send_word(OP_TICK, '0);
        send_word(OP_START, '0);
        repeat (2) send_word(OP_TICK, '0);

        run_phase(0,  0,  13'd16,   16'd65405, 24'd16776924, 16'd32768);
        run_phase(65, 0,  13'd5,    16'd65535, 24'd12000000, 16'd65535);
        run_phase(0,  65, 13'd0,    16'd0,     24'd16777215, 16'd32768);
        run_phase(35, 35, 13'd64,   16'd40000, 24'd15000000, 16'd20000);
        run_phase(0,  0,  13'd4096, 16'd65405, 24'd14000000, 16'd32768);
        run_phase(65, 0,  13'd1,    16'd65535, 24'd0,        16'd0);
        run_phase(0,  65, 13'd8191, 16'd30000, 24'd16000000, 16'd40000);
        run_phase(35, 35, 13'd3,    16'd50000, 24'd16777000, 16'd32769);
        run_phase(65, 65, 13'd436,  16'd65405, 24'd16776924, 16'd32768);

        @(negedge clk);
        in_valid = 1'b0;
        for (w = 0; w < 20000 && samples_owed != 0; w++)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (mismatch_count == 0 && samples_owed == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
